// ===== hw/rtl/kfci_pkg.sv =====
// ----------------------------------------------------------------------------
// kfci_pkg
// Shared types and constants of the keyframe color interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kfci_pkg;

	localparam int TIME_BITS_DEF     = 48;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int PROD_W            = 48;   // duration (32) times count (16)

	localparam logic [2:0] MODE_LINEAR      = 3'd0;
	localparam logic [2:0] MODE_EASE_IN     = 3'd1;
	localparam logic [2:0] MODE_EASE_OUT    = 3'd2;
	localparam logic [2:0] MODE_EASE_IN_OUT = 3'd3;
	localparam logic [2:0] MODE_EASE        = 3'd4;

	// Per-sample fields carried alongside the divider data
	typedef struct packed {
		logic [31:0] dur;      // zero already replaced by one
		logic        cnt_odd;  // bit 0 of the (fixed) iteration count
		logic        alt;
		logic [2:0]  mode;
		logic        done;
		logic [31:0] from;
		logic [31:0] to;
	} side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/keyframe_color_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_color_interpolator_top
// Animation sample to eased progress and blended RGBA color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one sample word per cycle while
//   in_ready is high: times, duration, count, flags, timing mode and two RGBA
//   colors. Output channel (out_valid/out_ready) returns one word per sample,
//   in order: the mixed color, the eased progress (Q1.FRACTION_BITS, one =
//   2^FRACTION_BITS) and the finished flag.
//   Throughput: one word per cycle while in_ready is high. Pipeline: 3 front
//   stages, one divider cell per quotient bit, 4 curve and blend stages, the
//   output register.
//   The latency is set by the row of division cells, which yields the cycle
//   parity and the Q0.FRACTION_BITS progress one quotient bit per cell.
//   Reset clears every valid bit; no clearing pass is needed.
//   When the receiver stalls, the output register holds its word and the
//   pipeline keeps advancing into empty slots; in_ready drops only when a
//   held word and a full last stage meet.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_color_interpolator_top #(
	parameter int TIME_BITS     = kfci_pkg::TIME_BITS_DEF,
	parameter int FRACTION_BITS = kfci_pkg::FRACTION_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [TIME_BITS-1:0]       now_ms,
	input  wire [TIME_BITS-1:0]       origin_ms,
	input  wire [31:0]                lead_ms,
	input  wire [31:0]                period_ms,
	input  wire [15:0]                loop_cnt,
	input  wire                       infinite,
	input  wire                       alternate,
	input  wire [2:0]                 timing_mode,
	input  wire [31:0]                from_rgba,
	input  wire [31:0]                to_rgba,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [31:0]               mixed_rgba,
	output logic [FRACTION_BITS:0]    eased_progress,
	output logic                      finished
);
	import kfci_pkg::*;

	localparam int N_CELLS = TIME_BITS + FRACTION_BITS;
	localparam int Q_W     = FRACTION_BITS + 1;

	logic                 en, out_take;
	logic                 f_vld;
	logic [TIME_BITS-1:0] f_elapsed;
	side_t                f_side;

	logic                 c_vld  [N_CELLS+1];
	logic [31:0]          c_rem  [N_CELLS+1];
	logic [N_CELLS-1:0]   c_dvd  [N_CELLS+1];
	logic [Q_W-1:0]       c_quo  [N_CELLS+1];
	side_t                c_side [N_CELLS+1];

	logic                 m_vld, m_done;
	logic [31:0]          m_rgba;
	logic [Q_W-1:0]       m_eased;

	logic                 out_valid_q, finished_q;
	logic [31:0]          mixed_rgba_q;
	logic [Q_W-1:0]       eased_q;

	// Load the output register when it is empty or being read; advance the
	// pipeline then, or whenever its last stage holds a bubble.
	assign out_take = !out_valid_q || out_ready;
	assign en       = out_take || !m_vld;
	assign in_ready = en;

	kfci_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk, .arst_n, .en,
		.vld_i(in_valid & en),
		.now_ms, .origin_ms, .lead_ms, .period_ms, .loop_cnt,
		.infinite, .alternate, .timing_mode, .from_rgba, .to_rgba,
		.vld_o(f_vld), .elapsed_o(f_elapsed), .side_o(f_side)
	);

	// Seed the division row: dividend is elapsed with FRACTION_BITS zeros
	// appended, so the low quotient bits are the progress fraction.
	assign c_vld[0]  = f_vld;
	assign c_rem[0]  = '0;
	assign c_dvd[0]  = {f_elapsed, {FRACTION_BITS{1'b0}}};
	assign c_quo[0]  = '0;
	assign c_side[0] = f_side;

	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		kfci_div_cell #(.DVD_W(N_CELLS), .Q_W(Q_W)) u_cell (
			.clk, .arst_n, .en,
			.vld_i(c_vld[g]), .rem_i(c_rem[g]), .dvd_i(c_dvd[g]),
			.quo_i(c_quo[g]), .side_i(c_side[g]),
			.vld_o(c_vld[g+1]), .rem_o(c_rem[g+1]), .dvd_o(c_dvd[g+1]),
			.quo_o(c_quo[g+1]), .side_o(c_side[g+1])
		);
	end

	kfci_mix #(.FRACTION_BITS(FRACTION_BITS)) u_mix (
		.clk, .arst_n, .en,
		.vld_i(c_vld[N_CELLS]), .quo_i(c_quo[N_CELLS]), .side_i(c_side[N_CELLS]),
		.vld_o(m_vld), .rgba_o(m_rgba), .eased_o(m_eased), .done_o(m_done)
	);

	// Output register: hold the word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= m_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			mixed_rgba_q <= m_rgba;
			eased_q      <= m_eased;
			finished_q   <= m_done;
		end
	end

	assign out_valid      = out_valid_q;
	assign mixed_rgba     = mixed_rgba_q;
	assign eased_progress = eased_q;
	assign finished       = finished_q;

	// Input stalls only when a held word blocks a full last stage.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && m_vld))
		else $error("input stalled without a blocked result");

	// Eased progress never exceeds one.
	a_progress_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (eased_progress <= (Q_W'(1) << FRACTION_BITS)))
		else $error("eased progress above one");

	// The row never loses a word while stalled.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_vld && !en) |=> m_vld)
		else $error("last stage word dropped during stall");

endmodule

`default_nettype wire

// ===== hw/rtl/kfci_front.sv =====
// ----------------------------------------------------------------------------
// kfci_front
// Elapsed time after the delay, total length and the finished flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kfci_front #(
	parameter int TIME_BITS = kfci_pkg::TIME_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    vld_i,
	input  wire [TIME_BITS-1:0]    now_ms,
	input  wire [TIME_BITS-1:0]    origin_ms,
	input  wire [31:0]             lead_ms,
	input  wire [31:0]             period_ms,
	input  wire [15:0]             loop_cnt,
	input  wire                    infinite,
	input  wire                    alternate,
	input  wire [2:0]              timing_mode,
	input  wire [31:0]             from_rgba,
	input  wire [31:0]             to_rgba,
	output logic                   vld_o,
	output logic [TIME_BITS-1:0]   elapsed_o,
	output kfci_pkg::side_t        side_o
);
	import kfci_pkg::*;

	localparam int CMP_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;

	logic                 vld_s1, vld_s2, vld_s3;
	logic [TIME_BITS-1:0] d_s1, elapsed_s2, elapsed_s3;
	logic                 pos_s1;
	logic [31:0]          delay_s1;
	logic [15:0]          cnt_s1;
	logic                 inf_s1, inf_s2;
	side_t                side_s1, side_s2, side_s3, side_fin;
	logic [PROD_W-1:0]    prod_s2;
	logic [TIME_BITS-1:0] delay_ext;
	logic [CMP_W-1:0]     el_cmp, prod_cmp;

	assign delay_ext = TIME_BITS'(delay_s1);
	assign el_cmp    = CMP_W'(elapsed_s2);
	assign prod_cmp  = CMP_W'(prod_s2);

	// finished: not infinite and all iterations have elapsed
	always_comb begin
		side_fin      = side_s2;
		side_fin.done = !inf_s2 && (el_cmp >= prod_cmp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: time since start, fix zero duration and count
			pos_s1           <= now_ms > origin_ms;
			d_s1             <= now_ms - origin_ms;
			delay_s1         <= lead_ms;
			cnt_s1           <= (loop_cnt == 16'd0) ? 16'd1 : loop_cnt;
			inf_s1           <= infinite;
			side_s1.dur      <= (period_ms == 32'd0) ? 32'd1 : period_ms;
			side_s1.cnt_odd  <= (loop_cnt == 16'd0) ? 1'b1 : loop_cnt[0];
			side_s1.alt      <= alternate;
			side_s1.mode     <= timing_mode;
			side_s1.done     <= 1'b0;
			side_s1.from     <= from_rgba;
			side_s1.to       <= to_rgba;
			// stage 2: drop the delay, total length of all iterations
			elapsed_s2       <= (pos_s1 && d_s1 > delay_ext) ? d_s1 - delay_ext : '0;
			prod_s2          <= PROD_W'(side_s1.dur) * PROD_W'(cnt_s1);
			inf_s2           <= inf_s1;
			side_s2          <= side_s1;
			// stage 3: finished flag
			elapsed_s3       <= elapsed_s2;
			side_s3          <= side_fin;
		end
	end

	assign vld_o     = vld_s3;
	assign elapsed_o = elapsed_s3;
	assign side_o    = side_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/kfci_div_cell.sv =====
// ----------------------------------------------------------------------------
// kfci_div_cell
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module kfci_div_cell #(
	parameter int DVD_W = 64,
	parameter int Q_W   = 17
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire                vld_i,
	input  wire [31:0]         rem_i,
	input  wire [DVD_W-1:0]    dvd_i,
	input  wire [Q_W-1:0]      quo_i,
	input  kfci_pkg::side_t    side_i,
	output logic               vld_o,
	output logic [31:0]        rem_o,
	output logic [DVD_W-1:0]   dvd_o,
	output logic [Q_W-1:0]     quo_o,
	output kfci_pkg::side_t    side_o
);
	import kfci_pkg::*;

	logic [32:0] trial, dur_ext, diff;
	logic        ge;
	logic        vld_s1;
	logic [31:0] rem_s1;
	logic [DVD_W-1:0] dvd_s1;
	logic [Q_W-1:0]   quo_s1;
	side_t            side_s1;

	assign trial   = {rem_i, dvd_i[DVD_W-1]};
	assign dur_ext = {1'b0, side_i.dur};
	assign ge      = trial >= dur_ext;
	assign diff    = trial - dur_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? diff[31:0] : trial[31:0];
			dvd_s1  <= {dvd_i[DVD_W-2:0], 1'b0};
			quo_s1  <= {quo_i[Q_W-2:0], ge};
			side_s1 <= side_i;
		end
	end

	assign vld_o  = vld_s1;
	assign rem_o  = rem_s1;
	assign dvd_o  = dvd_s1;
	assign quo_o  = quo_s1;
	assign side_o = side_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/kfci_mix.sv =====
// ----------------------------------------------------------------------------
// kfci_mix
// Progress select, timing curve and per-channel color blend.
// ----------------------------------------------------------------------------
`default_nettype none

module kfci_mix #(
	parameter int FRACTION_BITS = kfci_pkg::FRACTION_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  wire                        vld_i,
	input  wire [FRACTION_BITS:0]      quo_i,
	input  kfci_pkg::side_t            side_i,
	output logic                       vld_o,
	output logic [31:0]                rgba_o,
	output logic [FRACTION_BITS:0]     eased_o,
	output logic                       done_o
);
	import kfci_pkg::*;

	localparam int FB   = FRACTION_BITS;
	localparam int P_W  = FB + 1;
	localparam int SQ_W = 2 * P_W + 1;
	localparam int PR_W = 8 + P_W;
	localparam logic [P_W-1:0]  ONE     = P_W'(1) << FB;
	localparam logic [P_W-1:0]  HALF    = P_W'(1) << (FB - 1);
	localparam logic [SQ_W-1:0] ONE_W   = SQ_W'(1) << FB;
	localparam logic [SQ_W-1:0] HALF_W  = SQ_W'(1) << (FB - 1);
	localparam logic [SQ_W-1:0] QUART_W = SQ_W'(1) << (FB - 2);

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [P_W-1:0]   p_s1, p_raw, p_s2;
	logic [2:0]       mode_s1, mode_s2;
	logic             done_s1, done_s2, done_s3, done_s4;
	logic [31:0]      from_s1, from_s2, from_s3, to_s1, to_s2, to_s3;
	logic             odd;
	logic [P_W-1:0]   x;
	logic             hi_s2;
	logic [SQ_W-1:0]  sq_s2, r_in, r_lo, r_hi;
	logic [P_W-1:0]   e_n, e_s3, e_s4;
	logic [PR_W-1:0]  pa_s4 [4];
	logic [PR_W-1:0]  pb_s4 [4];
	logic [PR_W:0]    sum [4];

	// cycle parity: clamped to count - 1 once finished
	assign odd   = side_i.done ? !side_i.cnt_odd : quo_i[FB];
	assign p_raw = side_i.done ? ONE : {1'b0, quo_i[FB-1:0]};

	// square operand for each curve
	always_comb begin
		case (mode_s1) inside
			MODE_EASE_IN:  x = p_s1;
			MODE_EASE_OUT: x = ONE - p_s1;
			MODE_EASE_IN_OUT, MODE_EASE:
				x = (p_s1 < HALF) ? p_s1 : P_W'(({1'b0, ONE} << 1) - ({1'b0, p_s1} << 1));
			default:       x = p_s1;
		endcase
	end

	assign r_in = (sq_s2 + HALF_W) >> FB;
	assign r_lo = (sq_s2 + QUART_W) >> (FB - 1);
	assign r_hi = (sq_s2 + ONE_W) >> (FB + 1);

	always_comb begin
		case (mode_s2) inside
			MODE_EASE_IN:  e_n = r_in[P_W-1:0];
			MODE_EASE_OUT: e_n = ONE - r_in[P_W-1:0];
			[MODE_EASE_IN_OUT:MODE_EASE]:
				e_n = hi_s2 ? ONE - r_hi[P_W-1:0] : r_lo[P_W-1:0];
			default:       e_n = p_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= (side_i.alt && odd) ? ONE - p_raw : p_raw;
			mode_s1 <= side_i.mode;
			done_s1 <= side_i.done;
			from_s1 <= side_i.from;
			to_s1   <= side_i.to;

			sq_s2   <= SQ_W'(x) * SQ_W'(x);
			hi_s2   <= p_s1 >= HALF;
			p_s2    <= p_s1;
			mode_s2 <= mode_s1;
			done_s2 <= done_s1;
			from_s2 <= from_s1;
			to_s2   <= to_s1;

			e_s3    <= e_n;
			done_s3 <= done_s2;
			from_s3 <= from_s2;
			to_s3   <= to_s2;

			e_s4    <= e_s3;
			done_s4 <= done_s3;
			for (int i = 0; i < 4; i++) begin
				pa_s4[i] <= PR_W'(from_s3[8*i +: 8]) * PR_W'(ONE - e_s3);
				pb_s4[i] <= PR_W'(to_s3[8*i +: 8]) * PR_W'(e_s3);
			end
		end
	end

	// blend: round to nearest, result always within 0..255
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum[i] = (PR_W + 1)'(pa_s4[i]) + (PR_W + 1)'(pb_s4[i]) + (PR_W + 1)'(HALF);
			rgba_o[8*i +: 8] = sum[i][FB +: 8];
		end
	end

	assign vld_o   = vld_s4;
	assign eased_o = e_s4;
	assign done_o  = done_s4;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives animation samples into the keyframe color interpolator and checks
// each output word against a bit-accurate predictor of progress, easing and
// channel blending.
// ----------------------------------------------------------------------------

// Scoreboard: predict one output word per accepted sample, check in order
class color_scoreboard;
	logic [31:0] exp_rgba_q[$];
	logic [16:0] exp_prog_q[$];
	bit          exp_done_q[$];
	int          fail_cnt;

	function logic [63:0] round_sq(logic [63:0] x);
		return (x * x + 64'd32768) >> 16;
	endfunction

	function logic [63:0] apply_curve(logic [2:0] mode, logic [63:0] p);
		logic [63:0] q;
		case (mode)
			kfci_pkg::MODE_EASE_IN: return round_sq(p);
			kfci_pkg::MODE_EASE_OUT: return 64'd65536 - round_sq(64'd65536 - p);
			kfci_pkg::MODE_EASE_IN_OUT, kfci_pkg::MODE_EASE: begin
				if (p < 64'd32768)
					return (2 * p * p + 64'd32768) >> 16;
				q = 64'd131072 - 2 * p;
				return 64'd65536 - ((q * q + 64'd65536) >> 17);
			end
			default: return p;
		endcase
	endfunction

	function void note_sample(logic [47:0] now_t, logic [47:0] start_t, logic [31:0] delay,
			logic [31:0] dur_in, logic [15:0] cnt_in, bit inf, bit alt,
			logic [2:0] mode, logic [31:0] from_c, logic [31:0] to_c);
		logic [63:0] dur, cnt, elapsed, diff, cycle, prog, e, a, b, v;
		logic [31:0] rgba;
		bit done;
		dur = (dur_in == 0) ? 64'd1 : 64'(dur_in);
		cnt = (cnt_in == 0) ? 64'd1 : 64'(cnt_in);
		elapsed = 0;
		if (now_t > start_t) begin
			diff = 64'(now_t) - 64'(start_t);
			if (diff > 64'(delay))
				elapsed = diff - 64'(delay);
		end
		cycle = elapsed / dur;
		if (!inf && cycle >= cnt)
			cycle = cnt - 1;
		prog = ((elapsed % dur) << 16) / dur;
		done = !inf && (elapsed >= dur * cnt);
		if (done)
			prog = 64'd65536;
		if (alt && cycle[0])
			prog = 64'd65536 - prog;
		e = apply_curve(mode, prog);
		for (int s = 0; s < 32; s += 8) begin
			a = (from_c >> s) & 8'hFF;
			b = (to_c >> s) & 8'hFF;
			v = (a * (64'd65536 - e) + b * e + 64'd32768) >> 16;
			if (v > 255)
				v = 255;
			rgba[s +: 8] = v[7:0];
		end
		exp_rgba_q.insert(exp_rgba_q.size(), rgba);
		exp_prog_q.insert(exp_prog_q.size(), e[16:0]);
		exp_done_q.insert(exp_done_q.size(), done);
	endfunction

	function void check_word(logic [31:0] rgba, logic [16:0] prog, logic done);
		if (exp_rgba_q.size() == 0) begin
			$error("unexpected output word rgba=%h", rgba);
			fail_cnt++;
			return;
		end
		if (rgba !== exp_rgba_q[0]) begin
			$error("mixed_rgba expected %h actual %h", exp_rgba_q[0], rgba);
			fail_cnt++;
		end
		if (prog !== exp_prog_q[0]) begin
			$error("eased_progress expected %0d actual %0d", exp_prog_q[0], prog);
			fail_cnt++;
		end
		if (done !== exp_done_q[0]) begin
			$error("finished expected %0d actual %0d", exp_done_q[0], done);
			fail_cnt++;
		end
		void'(exp_rgba_q.pop_front());
		void'(exp_prog_q.pop_front());
		void'(exp_done_q.pop_front());
	endfunction
endclass

module tb;
	import kfci_pkg::*;

	localparam int LATENCY = 72;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [47:0] now_ms = 0;
	logic [47:0] origin_ms = 0;
	logic [31:0] lead_ms = 0;
	logic [31:0] period_ms = 0;
	logic [15:0] loop_cnt = 0;
	logic        infinite = 0;
	logic        alternate = 0;
	logic [2:0]  timing_mode = MODE_LINEAR;
	logic [31:0] from_rgba = 0;
	logic [31:0] to_rgba = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] mixed_rgba;
	logic [16:0] eased_progress;
	logic        finished;

	color_scoreboard sb;
	bit              feed_done = 0;

	keyframe_color_interpolator_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.now_ms(now_ms), .origin_ms(origin_ms), .lead_ms(lead_ms),
		.period_ms(period_ms), .loop_cnt(loop_cnt),
		.infinite(infinite), .alternate(alternate), .timing_mode(timing_mode),
		.from_rgba(from_rgba), .to_rgba(to_rgba),
		.out_valid(out_valid), .out_ready(out_ready),
		.mixed_rgba(mixed_rgba), .eased_progress(eased_progress), .finished(finished)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one, often none at all
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one sample word and hold it until the handshake completes;
	// drop valid only when a gap follows
	task automatic send_sample(logic [47:0] n, logic [47:0] st, logic [31:0] dl,
			logic [31:0] du, logic [15:0] ic, bit inf, bit alt, logic [2:0] md,
			logic [31:0] fr, logic [31:0] tr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		now_ms <= n; origin_ms <= st; lead_ms <= dl; period_ms <= du;
		loop_cnt <= ic; infinite <= inf; alternate <= alt;
		timing_mode <= md; from_rgba <= fr; to_rgba <= tr;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_sample(n, st, dl, du, ic, inf, alt, md, fr, tr);
	endtask

	// Build a well-formed sample near the active window of its animation
	task automatic send_random();
		logic [47:0] st, n;
		logic [31:0] dl, du;
		logic [15:0] ic;
		logic [63:0] span;
		int kind;
		kind = $urandom_range(0, 9);
		st = 48'({$urandom, $urandom});
		dl = (kind == 0) ? $urandom : $urandom_range(0, 2000);
		du = (kind == 1) ? $urandom : $urandom_range(0, 5000);
		ic = (kind == 2) ? 16'($urandom) : 16'($urandom_range(0, 6));
		span = 64'(dl) + 64'(du) * ((ic == 0) ? 64'd1 : 64'(ic)) + 64'd4000;
		if (kind == 3)
			n = 48'({$urandom, $urandom});
		else begin
			n = st + 48'({$urandom, $urandom} % span);
			if ($urandom_range(0, 7) == 0)
				n = st - 48'($urandom_range(0, 100));
		end
		send_sample(n, st, dl, du, ic, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
			3'($urandom_range(0, 7)), $urandom, $urandom);
	endtask

	// Drain output words; stall the receiver at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_word(mixed_rgba, eased_progress, finished);
			out_ready <= (pick_gap() == 0);
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every mode, each special case
		send_sample(0, 0, 0, 0, 0, 0, 0, MODE_LINEAR, 0, 32'hFFFF_FFFF);
		send_sample(48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, MODE_LINEAR, 32'hFFFF_FFFF, 0);
		send_sample(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 1, 1, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(48'hFFFF_FFFF_FFFF, 48'hFFFF_0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 0, 1, MODE_EASE, 32'h1234_5678, 32'h89AB_CDEF);
		// Start plus delay beyond the time range: never started
		send_sample(48'h0000_0000_1000, 48'hFFFF_FFFF_F000, 32'hFFFF_FFFF, 100, 1, 0, 0,
			MODE_LINEAR, 32'h00FF_00FF, 32'hFF00_FF00);
		// Exactly at start plus delay
		send_sample(1100, 1000, 100, 400, 2, 0, 0, MODE_LINEAR, 0, 32'hFFFF_FFFF);
		for (int m = 0; m < 8; m++) begin
			send_sample(1250, 1000, 0, 1000, 3, 0, 0, 3'(m), 32'h1020_3040, 32'hF0E0_D0C0);
			send_sample(1750, 1000, 0, 1000, 3, 0, 1, 3'(m), 32'h0000_0000, 32'hFFFF_FFFF);
		end
		// Finished, finished with alternate on even last cycle, infinite past end
		send_sample(5000, 0, 0, 1000, 2, 0, 1, MODE_LINEAR, 0, 32'hFFFF_FFFF);
		send_sample(5000, 0, 0, 1000, 3, 0, 1, MODE_EASE_IN, 0, 32'hFFFF_FFFF);
		send_sample(5500, 0, 0, 1000, 2, 1, 1, MODE_EASE_OUT, 0, 32'hFFFF_FFFF);
		send_sample(2000, 0, 0, 1000, 2, 0, 0, MODE_LINEAR, 32'hAA55_AA55, 32'h55AA_55AA);

		repeat (500) send_random();
		in_valid <= 0;
		feed_done = 1;
	end

	// End of run: wait for the queue to empty, then let the pipeline settle
	initial begin
		wait (feed_done);
		while (sb.exp_rgba_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog well above the slowest legal run
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
